>>> design/afd_pkg.sv
// Package for the ANT-FS message field decoder.
// Holds the transfer structs, kind and id codes, and the small code mapping functions.
// No dependencies.
`timescale 1ns / 1ps

package afd_pkg;

   // Input transfer: payload bytes 2 to 9 of one received message.
   typedef struct packed {
      logic [7:0] msg_class;
      logic [7:0] sub_byte;
      logic [7:0] byte_four;
      logic [7:0] byte_five;
      logic [7:0] byte_six;
      logic [7:0] byte_seven;
      logic [7:0] byte_eight;
      logic [7:0] byte_nine;
   } req_type;

   // Result transfer: the decoded fields of one message.
   typedef struct packed {
      logic [3:0]  kind;
      logic [2:0]  flags;
      logic [2:0]  period_code;
      logic [2:0]  state_code;
      logic [2:0]  sub_code;
      logic [15:0] word_a;
      logic [15:0] word_b;
      logic [31:0] dword_value;
      logic [7:0]  byte_a;
      logic [7:0]  byte_b;
      logic        freq_valid;
      logic [11:0] freq_mhz;
   } rsp_type;

   localparam int unsigned CHAN_W = 7;
   localparam logic [CHAN_W-1:0] CHAN_RESET = 7'd50;
   localparam logic [11:0] FREQ_BASE = 12'd2400;

   // Message classes.
   localparam logic [7:0] CLASS_BEACON = 8'h43;
   localparam logic [7:0] CLASS_CMD    = 8'h44;

   // Command and response ids carried in byte 3.
   localparam logic [7:0] ID_LINK       = 8'h02;
   localparam logic [7:0] ID_DISCONNECT = 8'h03;
   localparam logic [7:0] ID_AUTH       = 8'h04;
   localparam logic [7:0] ID_PING       = 8'h05;
   localparam logic [7:0] ID_DL_REQ     = 8'h09;
   localparam logic [7:0] ID_UL_REQ     = 8'h0a;
   localparam logic [7:0] ID_ERASE_REQ  = 8'h0b;
   localparam logic [7:0] ID_UL_DATA    = 8'h0c;
   localparam logic [7:0] ID_AUTH_RSP   = 8'h84;
   localparam logic [7:0] ID_DL_RSP     = 8'h89;
   localparam logic [7:0] ID_UL_RSP     = 8'h8a;
   localparam logic [7:0] ID_ERASE_RSP  = 8'h8b;
   localparam logic [7:0] ID_UL_DATA_RSP = 8'h8c;

   // Result kinds.
   localparam logic [3:0] KIND_BEACON      = 4'd0;
   localparam logic [3:0] KIND_LINK        = 4'd1;
   localparam logic [3:0] KIND_DISCONNECT  = 4'd2;
   localparam logic [3:0] KIND_AUTH        = 4'd3;
   localparam logic [3:0] KIND_PING        = 4'd4;
   localparam logic [3:0] KIND_DL_REQ      = 4'd5;
   localparam logic [3:0] KIND_UL_REQ      = 4'd6;
   localparam logic [3:0] KIND_ERASE_REQ   = 4'd7;
   localparam logic [3:0] KIND_UL_DATA     = 4'd8;
   localparam logic [3:0] KIND_AUTH_RSP    = 4'd9;
   localparam logic [3:0] KIND_DL_RSP      = 4'd10;
   localparam logic [3:0] KIND_UL_RSP      = 4'd11;
   localparam logic [3:0] KIND_ERASE_RSP   = 4'd12;
   localparam logic [3:0] KIND_UL_DATA_RSP = 4'd13;
   localparam logic [3:0] KIND_UNKNOWN_CMD = 4'd14;
   localparam logic [3:0] KIND_UNKNOWN     = 4'd15;

   // Period codes beyond the plain rates.
   localparam logic [2:0] PERIOD_MATCH    = 3'd5;
   localparam logic [2:0] PERIOD_RESERVED = 3'd6;
   localparam logic [7:0] PERIOD_MATCH_IN = 8'd7;

   // Top codes used for out-of-range selectors.
   localparam logic [2:0] TOP_STATE = 3'd4;
   localparam logic [2:0] TOP_AUTH  = 3'd4;
   localparam logic [2:0] TOP_RSP3  = 3'd3;
   localparam logic [2:0] TOP_RSP6  = 3'd6;

   // Disconnect type codes.
   localparam logic [2:0] DISC_RESERVED = 3'd2;
   localparam logic [2:0] DISC_DEVICE   = 3'd3;

   // Pass the selector through when it lies below the top code, else the top code.
   function automatic logic [2:0] cap_code(input logic [7:0] v, input logic [2:0] top);
      logic [2:0] res;
      res = (v < {5'd0, top}) ? v[2:0] : top;
      return res;
   endfunction

   // Map a raw period value onto the period code.
   function automatic logic [2:0] period_of(input logic [7:0] v);
      logic [2:0] res;
      if (v <= 8'd4) begin
         res = v[2:0];
      end else if (v == PERIOD_MATCH_IN) begin
         res = PERIOD_MATCH;
      end else begin
         res = PERIOD_RESERVED;
      end
      return res;
   endfunction

endpackage

>>> design/afd_csr.sv
// Configuration register of the ANT-FS message field decoder: the beacon channel.
// Depends on afd_pkg.
`timescale 1ns / 1ps

module afd_csr
   import afd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [CHAN_W-1:0] csr_wr_data,
   output logic [CHAN_W-1:0] beacon_channel
);

   logic [CHAN_W-1:0] channel_ff;
   logic [CHAN_W-1:0] channel_in;

   // A write replaces the channel; otherwise it holds.
   always_comb begin
      channel_in = csr_wr_en ? csr_wr_data : channel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_ff <= CHAN_RESET;
      end else begin
         channel_ff <= channel_in;
      end
   end

   assign beacon_channel = channel_ff;

endmodule

>>> design/afd_decode.sv
// Combinational field decode of one registered message into one result.
// Depends on afd_pkg.
`timescale 1ns / 1ps

module afd_decode
   import afd_pkg::*;
(
   input  req_type           msg,
   input  logic [CHAN_W-1:0] beacon_channel,
   output rsp_type           res
);

   logic [15:0] w45;
   logic [15:0] w67;
   logic [15:0] w89;
   logic [31:0] dw;
   logic [3:0]  st;

   // Little-endian words built from the byte positions.
   assign w45 = {msg.byte_five, msg.byte_four};
   assign w67 = {msg.byte_seven, msg.byte_six};
   assign w89 = {msg.byte_nine, msg.byte_eight};
   assign dw  = {w89, w67};
   assign st  = msg.byte_four[3:0];

   // Classify and pick the fields of the kind; unused fields stay zero.
   always_comb begin
      res = '0;
      if (msg.msg_class == CLASS_BEACON) begin
         res.kind        = KIND_BEACON;
         res.flags       = msg.sub_byte[5:3];
         res.period_code = period_of({5'd0, msg.sub_byte[2:0]});
         res.state_code  = cap_code({4'd0, st}, TOP_STATE);
         res.sub_code    = cap_code(msg.byte_five, TOP_AUTH);
         if (st == 4'd0) begin
            res.word_a = w67;
            res.word_b = w89;
         end else if (st == 4'd1 || st == 4'd2) begin
            res.dword_value = dw;
         end
      end else if (msg.msg_class == CLASS_CMD) begin
         case (msg.sub_byte)
            ID_LINK: begin
               res.kind        = KIND_LINK;
               res.byte_a      = msg.byte_four;
               res.period_code = period_of(msg.byte_five);
               res.dword_value = dw;
               res.freq_valid  = 1'b1;
               res.freq_mhz    = FREQ_BASE + {4'd0, msg.byte_four};
            end
            ID_DISCONNECT: begin
               res.kind = KIND_DISCONNECT;
               if (msg.byte_four inside {[8'd0:8'd1]}) begin
                  res.sub_code = msg.byte_four[2:0];
               end else if (msg.byte_four[7] == 1'b0) begin
                  res.sub_code = DISC_RESERVED;
               end else begin
                  res.sub_code = DISC_DEVICE;
               end
               res.byte_a     = msg.byte_five;
               res.byte_b     = msg.byte_six;
               res.freq_valid = 1'b1;
               res.freq_mhz   = FREQ_BASE + {5'd0, beacon_channel};
            end
            ID_AUTH: begin
               res.kind        = KIND_AUTH;
               res.sub_code    = cap_code(msg.byte_four, TOP_AUTH);
               res.byte_a      = msg.byte_five;
               res.dword_value = dw;
            end
            ID_PING: begin
               res.kind = KIND_PING;
            end
            ID_DL_REQ: begin
               res.kind        = KIND_DL_REQ;
               res.word_a      = w45;
               res.dword_value = dw;
            end
            ID_UL_REQ: begin
               res.kind        = KIND_UL_REQ;
               res.word_a      = w45;
               res.dword_value = dw;
            end
            ID_ERASE_REQ: begin
               res.kind   = KIND_ERASE_REQ;
               res.word_a = w45;
            end
            ID_UL_DATA: begin
               res.kind        = KIND_UL_DATA;
               res.word_a      = w45;
               res.dword_value = dw;
            end
            ID_AUTH_RSP: begin
               res.kind        = KIND_AUTH_RSP;
               res.sub_code    = cap_code(msg.byte_four, TOP_RSP3);
               res.byte_a      = msg.byte_five;
               res.dword_value = dw;
            end
            ID_DL_RSP: begin
               res.kind        = KIND_DL_RSP;
               res.sub_code    = cap_code(msg.byte_four, TOP_RSP6);
               res.dword_value = dw;
            end
            ID_UL_RSP: begin
               res.kind        = KIND_UL_RSP;
               res.sub_code    = cap_code(msg.byte_four, TOP_RSP6);
               res.dword_value = dw;
            end
            ID_ERASE_RSP: begin
               res.kind     = KIND_ERASE_RSP;
               res.sub_code = cap_code(msg.byte_four, TOP_RSP3);
            end
            ID_UL_DATA_RSP: begin
               res.kind  = KIND_UL_DATA_RSP;
               res.flags = {2'b00, (msg.byte_four != 8'd0)};
            end
            default: begin
               res.kind = KIND_UNKNOWN_CMD;
            end
         endcase
      end else begin
         res.kind = KIND_UNKNOWN;
      end
   end

endmodule

>>> design/antfs_message_field_decoder_core.sv
// Top level of the ANT-FS message field decoder: input register, decode, result register.
// Depends on afd_pkg, afd_csr and afd_decode.
`timescale 1ns / 1ps
//
// Usage:
// The req channel carries one received message per transfer as payload bytes 2 to 9
// (req_data). The rsp channel returns one decoded result per message (rsp_data):
// kind, flags, enumerated codes, words, byte fields and a frequency request.
// Both channels use valid/ready; a transfer happens when both are high.
// The csr port writes the beacon channel (csr_wr_en, csr_wr_data) with no wait; it
// is meant to be written while no message is in flight.
// An accepted message passes through the input register and then the result register
// before it shows on rsp; the decode between them is combinational.
// The core takes one message per cycle while the receiver does not stall, set by the
// two-register pipeline around the combinational decode.
// Reset clears both pipeline valid bits and sets the beacon channel to 50.
// When the receiver stalls, the result register holds; the input register still
// takes one more message, and req_ready drops only when both registers are full.
//

module antfs_message_field_decoder_core
   import afd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_wr_en,
   input  logic [CHAN_W-1:0] csr_wr_data
);

   logic              in_valid_ff;
   logic              in_valid_in;
   req_type           in_data_ff;
   logic              out_valid_ff;
   logic              out_valid_in;
   rsp_type           out_data_ff;
   rsp_type           decoded;
   logic [CHAN_W-1:0] beacon_channel;
   logic              out_load;
   logic              in_load;

   afd_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .beacon_channel (beacon_channel)
   );

   afd_decode u_decode (
      .msg            (in_data_ff),
      .beacon_channel (beacon_channel),
      .res            (decoded)
   );

   // Pipeline flow: the result register frees when empty or taken, the input
   // register frees when empty or when it moves forward.
   always_comb begin
      out_load     = !out_valid_ff || rsp_ready;
      in_load      = !in_valid_ff || out_load;
      in_valid_in  = in_load ? req_valid : in_valid_ff;
      out_valid_in = out_load ? in_valid_ff : out_valid_ff;
   end

   assign req_ready = in_load;

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (in_load) begin
         in_data_ff <= req_data;
      end
      if (out_load) begin
         out_data_ff <= decoded;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // An accepted transfer always lands in the input register.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> in_valid_ff)
      else $error("accepted message did not reach the input register");

   // Back pressure only when both registers are full and the receiver stalls.
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && out_valid_ff && !rsp_ready))
      else $error("req_ready low with room in the pipeline");

   // A frequency request comes only with link and disconnect results.
   a_freq_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.freq_valid ==
         (rsp_data.kind == KIND_LINK || rsp_data.kind == KIND_DISCONNECT)))
      else $error("frequency request on wrong kind");

   // Without a frequency request the frequency reads zero.
   a_freq_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.freq_valid) |-> (rsp_data.freq_mhz == 12'd0))
      else $error("frequency nonzero without request");

   // Reset restores the default beacon channel.
   a_chan_reset: assert property (@(posedge clock)
      reset |=> (beacon_channel == CHAN_RESET))
      else $error("beacon channel not restored by reset");

endmodule
